>>> hw/rtl/mpd_pkg.sv
// Package for the dilated 2-D max pooling core.
// Holds the sequencer state type, register indexes and coordinate width.
// No dependencies.
`timescale 1ns / 1ps

package mpd_pkg;

    // signed coordinate width for window taps (covers 63*15 + 7*15 and -7)
    localparam int COORD_W = 12;

    // configuration register indexes (paddr[4:2])
    localparam logic [2:0] REG_IN_HEIGHT   = 3'd0;
    localparam logic [2:0] REG_IN_WIDTH    = 3'd1;
    localparam logic [2:0] REG_KERNEL_SIZE = 3'd2;
    localparam logic [2:0] REG_STRIDE      = 3'd3;
    localparam logic [2:0] REG_PADDING     = 3'd4;
    localparam logic [2:0] REG_DILATION    = 3'd5;

    // query sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/max_pool_2d_dilated_core.sv
// Sequence: a load is written at its accepting edge; an in-range query goes through range
// check, one plane read per tap, drain and output load. A query past the output extent
// skips the scan and the drain and goes from the range check straight to the output load.
// Throughput: one item at a time; a load is taken while idle, and a query holds the input
// until its result is loaded, which waits behind any result not yet taken.
// Reset (rst_n, async low) restores register defaults and idles the sequencer; plane not cleared.
`timescale 1ns / 1ps

module max_pool_2d_dilated_core
    import mpd_pkg::*;
#(
    parameter int MAX_HEIGHT  = 64,
    parameter int MAX_WIDTH   = 64,
    parameter int MAX_KERNEL  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // row [5:0], col [11:6], sample [12 +: SAMPLE_BITS], zero fill above
    input  logic [((12 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // mode [0]: 0 load, 1 query
    input  logic                   s_tuser,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // max_value [SAMPLE_BITS-1:0], zero fill above
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // window_empty [0], out_of_range [1]
    output logic [1:0]             m_tuser,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DEPTH      = MAX_HEIGHT * MAX_WIDTH;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KIDX_W     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int KCNT_W     = $clog2(MAX_KERNEL + 1);

    localparam logic [SAMPLE_BITS-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // configuration registers
    logic [6:0] in_height_reg, in_width_reg;
    logic [3:0] kernel_size_reg, stride_reg;
    logic [2:0] padding_reg, dilation_reg;

    // sequencer registers
    state_t                      state_reg, state_next;
    logic [5:0]                  row_reg, row_next;
    logic [5:0]                  col_reg, col_next;
    logic signed [COORD_W-1:0]   r_reg, r_next;
    logic signed [COORD_W-1:0]   c_reg, c_next;
    logic signed [COORD_W-1:0]   c0_reg, c0_next;
    logic [KIDX_W-1:0]           kh_reg, kh_next;
    logic [KIDX_W-1:0]           kw_reg, kw_next;
    logic signed [SAMPLE_BITS-1:0] best_reg, best_next;
    logic                        found_reg, found_next;
    logic                        oor_reg, oor_next;
    logic                        rd_pend_reg, rd_pend_next;

    // output register
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0]      out_max_reg, out_max_next;
    logic                        out_empty_reg, out_empty_next;
    logic                        out_oor_reg, out_oor_next;

    // plane memory
    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic                          wr_en, rd_en;
    logic [ADDR_W-1:0]             waddr, raddr;

    // effective (clamped) settings
    logic [6:0]                h_eff, w_eff;
    logic [KCNT_W-1:0]         k_eff;
    logic [KIDX_W-1:0]         k_m1;
    logic [3:0]                s_eff;
    logic [2:0]                d_eff;
    logic signed [COORD_W-1:0] h_s, w_s, p_s, d_s, span, num_h, num_w, rs, cs;
    logic                      tap_in, last_kw, last_kh, take;
    logic                      s_accept, cfg_wr;
    logic [5:0]                in_row, in_col;
    logic [SAMPLE_BITS-1:0]    in_sample;

    assign in_row    = s_tdata[5:0];
    assign in_col    = s_tdata[11:6];
    assign in_sample = s_tdata[12 +: SAMPLE_BITS];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg   <= 7'd64;
            in_width_reg    <= 7'd64;
            kernel_size_reg <= 4'd2;
            stride_reg      <= 4'd2;
            padding_reg     <= 3'd0;
            dilation_reg    <= 3'd1;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_IN_HEIGHT:   in_height_reg   <= pwdata[6:0];
                REG_IN_WIDTH:    in_width_reg    <= pwdata[6:0];
                REG_KERNEL_SIZE: kernel_size_reg <= pwdata[3:0];
                REG_STRIDE:      stride_reg      <= pwdata[3:0];
                REG_PADDING:     padding_reg     <= pwdata[2:0];
                REG_DILATION:    dilation_reg    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_IN_HEIGHT:   prdata = 32'(in_height_reg);
            REG_IN_WIDTH:    prdata = 32'(in_width_reg);
            REG_KERNEL_SIZE: prdata = 32'(kernel_size_reg);
            REG_STRIDE:      prdata = 32'(stride_reg);
            REG_PADDING:     prdata = 32'(padding_reg);
            REG_DILATION:    prdata = 32'(dilation_reg);
            default:         prdata = 32'd0;
        endcase
    end

    // ---------------- clamped settings and extents ----------------
    always_comb
    begin
        h_eff = (32'(in_height_reg) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : in_height_reg;
        w_eff = (32'(in_width_reg) > MAX_WIDTH) ? 7'(MAX_WIDTH) : in_width_reg;
        if (kernel_size_reg == 4'd0)
            k_eff = KCNT_W'(1);
        else if (32'(kernel_size_reg) > MAX_KERNEL)
            k_eff = KCNT_W'(MAX_KERNEL);
        else
            k_eff = KCNT_W'(kernel_size_reg);
        k_m1  = KIDX_W'(k_eff - KCNT_W'(1));
        s_eff = (stride_reg == 4'd0) ? 4'd1 : stride_reg;
        d_eff = (dilation_reg == 3'd0) ? 3'd1 : dilation_reg;
    end

    assign h_s  = COORD_W'(h_eff);
    assign w_s  = COORD_W'(w_eff);
    assign p_s  = COORD_W'(padding_reg);
    assign d_s  = COORD_W'(d_eff);
    assign span = COORD_W'(COORD_W'(d_eff) * COORD_W'(k_m1));
    // last valid window origin per axis; row < extent <=> row*s <= num
    assign num_h = h_s + (p_s <<< 1) - span - COORD_W'(1);
    assign num_w = w_s + (p_s <<< 1) - span - COORD_W'(1);
    assign rs    = COORD_W'(COORD_W'(row_reg) * COORD_W'(s_eff));
    assign cs    = COORD_W'(COORD_W'(col_reg) * COORD_W'(s_eff));

    // ---------------- tap address generation ----------------
    assign tap_in  = !r_reg[COORD_W-1] && (r_reg < h_s) && !c_reg[COORD_W-1] && (c_reg < w_s);
    assign last_kw = (kw_reg == k_m1);
    assign last_kh = (kh_reg == k_m1);
    assign raddr   = ADDR_W'(32'(r_reg[COORD_W-2:0]) * 32'(MAX_WIDTH)
                             + 32'(c_reg[COORD_W-2:0]));
    assign waddr   = ADDR_W'(32'(in_row) * 32'(MAX_WIDTH) + 32'(in_col));

    assign s_accept = s_tvalid & s_tready;
    assign wr_en    = s_accept & !s_tuser
                      & (32'(in_row) < MAX_HEIGHT) & (32'(in_col) < MAX_WIDTH);
    assign rd_en    = (state_reg == ST_SCAN) & tap_in;

    // plane memory: one write port (loads), one registered read port (scan)
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr] <= in_sample;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[raddr];
    end

    // ---------------- sequencer ----------------
    assign take = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        c0_next        = c0_reg;
        kh_next        = kh_reg;
        kw_next        = kw_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        oor_next       = oor_reg;
        rd_pend_next   = rd_en;
        m_tvalid_next  = m_tvalid_reg & !m_tready;
        out_max_next   = out_max_reg;
        out_empty_next = out_empty_reg;
        out_oor_next   = out_oor_reg;
        s_tready       = 1'b0;

        // shared compare stage: fold the tap read last cycle into the maximum
        if (rd_pend_reg && (!found_reg || rdata_reg > best_reg))
            best_next = rdata_reg;
        if (rd_pend_reg)
            found_next = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser)
                begin
                    row_next   = in_row;
                    col_next   = in_col;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                best_next  = MIN_SAMPLE;
                found_next = 1'b0;
                kh_next    = '0;
                kw_next    = '0;
                r_next     = rs - p_s;
                c_next     = cs - p_s;
                c0_next    = cs - p_s;
                oor_next   = (rs > num_h) || (cs > num_w);
                state_next = ((rs > num_h) || (cs > num_w)) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (last_kw)
                begin
                    kw_next = '0;
                    c_next  = c0_reg;
                    kh_next = kh_reg + KIDX_W'(1);
                    r_next  = r_reg + d_s;
                    if (last_kh)
                        state_next = ST_DRAIN;
                end
                else
                begin
                    kw_next = kw_reg + KIDX_W'(1);
                    c_next  = c_reg + d_s;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (take)
                begin
                    m_tvalid_next  = 1'b1;
                    out_max_next   = best_reg;
                    out_empty_next = !found_reg;
                    out_oor_next   = oor_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            c0_reg        <= '0;
            kh_reg        <= '0;
            kw_reg        <= '0;
            best_reg      <= '0;
            found_reg     <= 1'b0;
            oor_reg       <= 1'b0;
            out_max_reg   <= '0;
            out_empty_reg <= 1'b0;
            out_oor_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            c0_reg        <= c0_next;
            kh_reg        <= kh_next;
            kw_reg        <= kw_next;
            best_reg      <= best_next;
            found_reg     <= found_next;
            oor_reg       <= oor_next;
            out_max_reg   <= out_max_next;
            out_empty_reg <= out_empty_next;
            out_oor_reg   <= out_oor_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(out_max_reg);
    assign m_tuser  = {out_oor_reg, out_empty_reg};

    // ---------------- assertions ----------------
    // an out-of-range result never carries a window maximum
    a_oor_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && m_tdata[SAMPLE_BITS-1:0] == MIN_SAMPLE))
        else $error("out-of-range result without empty window");

    // tap reads only land while the scan or its drain is running
    a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("tap read outside scan");

    // a finished result waits while the output register is still held
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

    // window row counter stays inside the kernel
    a_kh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (KCNT_W'(kh_reg) < k_eff))
        else $error("kernel row counter past window");

endmodule
